// ----- rtl/core/sha_pkg.sv -----
// Package: SHA-256 constants, controller types and round functions.
`default_nettype none
package sha_pkg;

  localparam logic [20:0] MAX_MESSAGE_BYTES = 21'd1048576;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_COMP,
    ST_PAD,
    ST_LEN,
    ST_DBL,
    ST_OUT,
    ST_ERR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       take_word;   // capture input word
    logic       put_byte;    // store next byte of held word
    logic       put_pad;     // store padding byte
    logic       put_len;     // write length words 14 and 15
    logic       comp_start;  // load working vars, round 0
    logic       comp_round;  // advance one round
    logic       comp_final;  // add into chaining value
    logic       load_dbl;    // build second block from digest
    logic       clear_msg;   // back to reset values
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       bytes_left;  // held word has bytes still to store
    logic       block_full;  // 64 bytes in buffer
    logic       fill_is_56;
    logic       too_long;
    logic       last_round;
  } stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sha_datapath.sv -----
// Datapath: byte packer, message schedule window, round registers, chaining value.
`default_nettype none
module sha_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sha_pkg::cmd_t cmd,
  output sha_pkg::stat_t     stat,
  input  wire logic [31:0]   in_word,
  input  wire logic [2:0]    in_count,
  output logic [31:0]        cv_word [8]
);
  import sha_pkg::*;

  logic [31:0] buf_r [16];
  logic [31:0] hold_r, hold_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic        full_r, full_nxt;
  logic [60:0] bytes_r, bytes_nxt;
  logic        tl_r, tl_nxt;
  logic [31:0] cv_r [8];
  logic [31:0] wv_r [8];
  logic [5:0]  rnd_r;
  logic        pad_started_r;

  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [31:0] w0, s0, s1, w_new, t1, t2, big0, big1, chv, mjv;

  assign cv_word = cv_r;

  assign stat.bytes_left = (left_r != 3'd0) && !tl_r;
  assign stat.block_full = full_r;
  assign stat.fill_is_56 = (fill_r == 6'd56) && !full_r && pad_started_r;
  assign stat.too_long   = tl_r;
  assign stat.last_round = (rnd_r == 6'd63);

  // padding byte 0x80 goes first; track it with a flag
  always_comb begin
    wr_en   = cmd.put_byte || cmd.put_pad;
    wr_byte = cmd.put_pad ? (!pad_started_r ? 8'h80 : 8'h00) : hold_r[31:24];
  end

  always_comb begin
    hold_nxt  = hold_r;
    left_nxt  = left_r;
    fill_nxt  = fill_r;
    full_nxt  = full_r;
    bytes_nxt = bytes_r;
    tl_nxt    = tl_r;
    if (cmd.take_word) begin
      hold_nxt = in_word;
      left_nxt = (in_count > 3'd4) ? 3'd4 : in_count;
    end
    if (cmd.put_byte) begin
      if (bytes_r[20:0] >= MAX_MESSAGE_BYTES || bytes_r[60:21] != '0) begin
        tl_nxt = 1'b1;
      end else begin
        hold_nxt  = {hold_r[23:0], 8'h00};
        left_nxt  = left_r - 3'd1;
        bytes_nxt = bytes_r + 61'd1;
      end
    end
    if (wr_en && !(cmd.put_byte && tl_nxt)) begin
      fill_nxt = fill_r + 6'd1;
      full_nxt = (fill_r == 6'd63);
    end
    if (cmd.comp_start) full_nxt = 1'b0;
    if (cmd.clear_msg) begin
      fill_nxt  = '0;
      full_nxt  = 1'b0;
      bytes_nxt = '0;
      tl_nxt    = 1'b0;
      left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r        <= '0;
      fill_r        <= '0;
      full_r        <= 1'b0;
      bytes_r       <= '0;
      tl_r          <= 1'b0;
      pad_started_r <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      fill_r  <= fill_nxt;
      full_r  <= full_nxt;
      bytes_r <= bytes_nxt;
      tl_r    <= tl_nxt;
      if (cmd.put_pad)        pad_started_r <= 1'b1;
      else if (cmd.clear_msg) pad_started_r <= 1'b0;
    end
    hold_r <= hold_nxt;
  end

  // schedule: buf_r acts as a 16-word window shifted once per round
  assign w0 = buf_r[0];
  assign s0 = rotr(buf_r[1], 7) ^ rotr(buf_r[1], 18) ^ (buf_r[1] >> 3);
  assign s1 = rotr(buf_r[14], 17) ^ rotr(buf_r[14], 19) ^ (buf_r[14] >> 10);
  assign w_new = buf_r[0] + s0 + buf_r[9] + s1;

  assign big1 = rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25);
  assign chv  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign t1   = wv_r[7] + big1 + chv + ROUND_K[rnd_r] + w0;
  assign big0 = rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22);
  assign mjv  = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t2   = big0 + mjv;

  always_ff @(posedge clk) begin
    if (wr_en && !(cmd.put_byte && tl_nxt)) begin
      unique case (fill_r[1:0])
        2'd0: buf_r[fill_r[5:2]]        <= {wr_byte, 24'h0};
        2'd1: buf_r[fill_r[5:2]][23:16] <= wr_byte;
        2'd2: buf_r[fill_r[5:2]][15:8]  <= wr_byte;
        default: buf_r[fill_r[5:2]][7:0] <= wr_byte;
      endcase
    end
    if (cmd.put_len) begin
      buf_r[14] <= bytes_r[60:29];
      buf_r[15] <= {bytes_r[28:0], 3'b000};
    end
    if (cmd.load_dbl) begin
      for (int i = 0; i < 8; i++) buf_r[i] <= cv_r[i];
      buf_r[8] <= 32'h80000000;
      for (int i = 9; i < 15; i++) buf_r[i] <= '0;
      buf_r[15] <= 32'd256;
    end
    if (cmd.comp_round) begin
      for (int i = 0; i < 15; i++) buf_r[i] <= buf_r[i + 1];
      buf_r[15] <= w_new;
      wv_r[7] <= wv_r[6]; wv_r[6] <= wv_r[5]; wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2]; wv_r[2] <= wv_r[1]; wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
    // second hash starts again from the initial values
    if (cmd.comp_start) begin
      if (cmd.load_dbl) wv_r <= INIT_H;
      else              wv_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
      cv_r  <= INIT_H;
    end else begin
      if (cmd.comp_start)      rnd_r <= '0;
      else if (cmd.comp_round) rnd_r <= rnd_r + 6'd1;
      if (cmd.comp_final) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] + wv_r[i];
      end
      if (cmd.clear_msg || cmd.load_dbl) cv_r <= INIT_H;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sha_ctrl.sv -----
// Controller: sequences absorb, padding, compression and digest output.
`default_nettype none
module sha_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           in_last,
  input  wire logic           dbl,
  input  wire sha_pkg::stat_t stat,
  input  wire logic           out_fire,
  output sha_pkg::cmd_t       cmd,
  output logic                in_ready,
  output logic                out_valid,
  output logic                out_err,
  output logic [2:0]          out_idx
);
  import sha_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, second_r, post_r;  // post_r: length written, final block
  logic   comp_fin;
  logic [2:0] idx_r;

  // compression ends once the round 63 flag is registered
  logic finish_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_ABSORB;
      ST_ABSORB: begin
        if (stat.block_full)      state_nxt = ST_COMP;
        else if (stat.bytes_left) state_nxt = ST_ABSORB;
        else if (!last_r)         state_nxt = ST_IDLE;
        else if (stat.too_long)   state_nxt = ST_ERR;
        else                      state_nxt = ST_PAD;
      end
      ST_PAD: begin
        if (stat.block_full)      state_nxt = ST_COMP;
        else if (stat.fill_is_56) state_nxt = ST_LEN;
      end
      ST_LEN:  state_nxt = ST_COMP;
      ST_COMP: if (finish_r) begin
        if (!post_r)                state_nxt = ST_ABSORB;
        else if (dbl && !second_r)  state_nxt = ST_DBL;
        else                        state_nxt = ST_OUT;
      end
      ST_DBL:  state_nxt = ST_COMP;
      ST_OUT:  if (out_fire && idx_r == 3'd7) state_nxt = ST_IDLE;
      ST_ERR:  if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign comp_fin = (state_r == ST_COMP) && finish_r;

  always_comb begin
    cmd = '0;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT) || (state_r == ST_ERR);
    out_err   = (state_r == ST_ERR);
    out_idx   = (state_r == ST_OUT) ? idx_r : 3'd0;
    cmd.take_word = in_fire;
    unique case (state_r)
      ST_ABSORB: cmd.put_byte = stat.bytes_left && !stat.block_full;
      ST_PAD:    cmd.put_pad  = !stat.block_full && !stat.fill_is_56;
      ST_LEN:    cmd.put_len  = 1'b1;
      ST_DBL:    cmd.load_dbl = 1'b1;
      ST_COMP: begin
        cmd.comp_round = !finish_r;
        cmd.comp_final = finish_r;
      end
      ST_OUT:  cmd.clear_msg = out_fire && idx_r == 3'd7;
      ST_ERR:  cmd.clear_msg = out_fire;
      default: ;
    endcase
    cmd.comp_start = (state_nxt == ST_COMP) && (state_r != ST_COMP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      last_r   <= 1'b0;
      second_r <= 1'b0;
      post_r   <= 1'b0;
      finish_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) last_r <= in_last;
      if (state_r == ST_LEN) post_r <= 1'b1;
      if (state_r == ST_DBL) second_r <= 1'b1;
      if (cmd.comp_start)       finish_r <= 1'b0;
      else if (cmd.comp_round)  finish_r <= stat.last_round;
      if (cmd.clear_msg) begin
        second_r <= 1'b0;
        post_r   <= 1'b0;
        idx_r    <= '0;
      end else if (out_fire && state_r == ST_OUT) begin
        idx_r <= idx_r + 3'd1;
      end
      if (comp_fin && !post_r) finish_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/sha256_stream_hasher.sv -----
// Top level: SHA-256 stream hasher with stream ports and mode register.
`default_nettype none
// Streaming SHA-256 (single or double). Each input transaction is accepted,
// then each of its valid bytes is stored into the block buffer, and then the
// controller decides what follows. A full 64-byte block runs through one
// shared round unit at one round per cycle: a start step that loads the
// working variables, 64 rounds and a step to add into the chaining value.
// At the end of a message the padding and length block follow, then the
// optional second hash, and then the eight digest words leave one per output
// transaction from the chaining value registers; the input is held off until
// they are taken. An over-long message gives one error result.
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // message_word[31:0], valid_bytes[34:32]
  input  wire logic        in_tlast,    // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // digest_word[31:0], word_index[34:32]
  output logic             out_tlast,   // last_of_digest
  output logic             out_tuser    // status
);
  import sha_pkg::*;

  logic   dbl_r;
  cmd_t   cmd;
  stat_t  stat;
  logic   in_fire, out_fire, err;
  logic [2:0] idx;
  logic [31:0] cv_word [8];

  always_ff @(posedge clk) begin
    if (!rst_n)      dbl_r <= 1'b0;
    else if (cfg_we) dbl_r <= cfg_wdata;
  end

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_tlast), .dbl(dbl_r), .stat,
    .out_fire, .cmd, .in_ready(in_tready), .out_valid(out_tvalid),
    .out_err(err), .out_idx(idx)
  );

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_word(in_tdata[31:0]),
    .in_count(in_tdata[34:32]), .cv_word
  );

  assign out_tdata = {5'd0, idx, err ? 32'd0 : cv_word[idx]};
  assign out_tlast = err || (idx == 3'd7);
  assign out_tuser = err;
endmodule
`default_nettype wire

// ----- sim/tb_sha256_stream_hasher.sv -----
// Testbench for the SHA-256 stream hasher: predicting scoreboard, stream drivers and checks.
`default_nettype none
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
    logic        status;
  } digest_res_t;

  class sha_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned fill;
    logic [63:0] bit_count;
    bit          overflow;
    bit          dbl_mode;
    digest_res_t pending [$];
    int          errors;

    function logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void restart_message();
      for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_H[i];
      fill = 0;
      bit_count = '0;
      overflow = 0;
    endfunction

    function new();
      restart_message();
      dbl_mode = 0;
      errors = 0;
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) r[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::ROUND_K[i] + w[i];
        t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
    endfunction

    function void store_byte(input logic [7:0] b);
      int unsigned wi;
      wi = fill >> 2;
      if ((fill & 3) == 0) blk[wi] = {b, 24'h0};
      else blk[wi] |= 32'(b) << (24 - 8 * (fill & 3));
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    // Absorb one accepted transaction; queue the digest words on the final one.
    function void note_input(input logic [31:0] word, input logic [2:0] cnt, input logic last);
      int unsigned n;
      digest_res_t e;
      n = (cnt > 4) ? 4 : cnt;
      for (int i = 0; i < n; i++) begin
        if (overflow) break;
        if ((bit_count >> 3) >= 64'(sha_pkg::MAX_MESSAGE_BYTES)) begin
          overflow = 1;
          break;
        end
        store_byte(word[31 - 8*i -: 8]);
        bit_count += 8;
      end
      if (!last) return;
      if (overflow) begin
        e.digest = '0; e.index = '0; e.last = 1; e.status = 1;
        pending.push_back(e);
        restart_message();
        return;
      end
      store_byte(8'h80);
      while (fill != 56) store_byte(8'h00);
      blk[14] = bit_count[63:32];
      blk[15] = bit_count[31:0];
      compress();
      if (dbl_mode) begin
        for (int i = 0; i < 8; i++) blk[i] = chain[i];
        blk[8] = 32'h80000000;
        for (int i = 9; i < 15; i++) blk[i] = '0;
        blk[15] = 32'd256;
        for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_H[i];
        compress();
      end
      for (int i = 0; i < 8; i++) begin
        e.digest = chain[i]; e.index = 3'(i); e.last = (i == 7); e.status = 0;
        pending.push_back(e);
      end
      restart_message();
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task check_result(input logic [39:0] data, input logic last, input logic status);
      digest_res_t e;
      if (pending.size() == 0) begin
        report("unexpected digest transaction", data[31:0], 32'h0);
        return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.digest) report("digest_word", data[31:0], e.digest);
      if (data[34:32] !== e.index) report("word_index", 32'(data[34:32]), 32'(e.index));
      if (last !== e.last) report("last_of_digest", 32'(last), 32'(e.last));
      if (status !== e.status) report("status", 32'(status), 32'(e.status));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  sha_scoreboard sb = new();
  int burst_left = 0;
  int digests_taken = 0;
  int items_sent = 0;

  always #2 clk = ~clk;

  sha256_stream_hasher u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(s_tvalid), .in_tready(s_tready),
    .in_tdata(s_tdata), .in_tlast(s_tlast),
    .out_tvalid(m_tvalid), .out_tready(m_tready),
    .out_tdata(m_tdata), .out_tlast(m_tlast), .out_tuser(m_tuser)
  );

  // Receiver: stall on a shifting pattern, with one long hold-off.
  initial begin
    int mode, hold, cyc;
    mode = 0; hold = 0; cyc = 0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tlast, m_tuser);
        digests_taken++;
        if (digests_taken == 40) hold = 800;
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else if (mode == 0) begin
        m_tready <= 1;
      end else begin
        m_tready <= ($urandom_range(0, 9) >= (mode == 1 ? 3 : 7));
      end
    end
  end

  task automatic send_item(input logic [31:0] w, input logic [2:0] c, input logic l);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1;
    s_tdata <= {5'b0, c, w};
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    sb.note_input(w, c, l);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_message(input int nwords);
    logic [2:0] c;
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(0, 9))
        0: c = 3'($urandom_range(0, 3));
        1: c = 3'($urandom_range(5, 7));
        default: c = 3'd4;
      endcase
      if (i == nwords - 1) c = 3'($urandom_range(0, 7));
      send_item($urandom, c, i == nwords - 1);
    end
  endtask

  // Hold the input low, drain every expected digest, let the core settle, then set the mode.
  task automatic drain_and_set(input logic mode);
    s_tvalid <= 0;
    s_tlast <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 0;
    sb.dbl_mode = mode;
    burst_left = 0;
  endtask

  task automatic random_phase(input int target);
    int goal;
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) send_item($urandom, 3'd0, 0);
      else if ($urandom_range(0, 9) == 0) send_message($urandom_range(14, 40));
      else send_message($urandom_range(1, 16));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    drain_and_set(0);

    // Directed: empty message, extremes of word and count, zero counts, boundaries.
    send_item(32'h0, 3'd0, 1);
    send_item(32'h61626300, 3'd3, 1);
    send_item(32'hffffffff, 3'd4, 0);
    send_item(32'h12345678, 3'd0, 0);
    send_item(32'h0, 3'd7, 0);
    send_item(32'hdeadbeef, 3'd1, 0);
    send_item(32'hffffffff, 3'd5, 1);
    for (int i = 0; i < 14; i++) send_item(32'hffffffff, 3'd4, i == 13); // 56 bytes
    drain_and_set(1);
    send_item(32'h0, 3'd0, 1);
    send_item(32'hffffffff, 3'd6, 1);
    random_phase(60);
    drain_and_set(0);
    random_phase(70);
    drain_and_set(1);
    random_phase(70);
    drain_and_set(0);
    random_phase(30);
    drain_and_set(1);
    send_item(32'h0, 3'd0, 1);
    s_tvalid <= 0;
    s_tlast <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
